// ----- rtl/sha1bc_pkg.sv -----
// shared types, constants and round functions for the sha1 block compression
package sha1bc_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_CHAIN  = 5;
    localparam int unsigned NUM_MSG    = 16;
    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned ROUND_W    = 7;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned DIDX_W     = 3;
    localparam int unsigned IN_USER_W  = 1 + IDX_W;

    localparam logic CMD_CHAIN = 1'b0;
    localparam logic CMD_MSG   = 1'b1;

    localparam logic [WORD_W-1:0] K0 = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62_C1D6;

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(NUM_ROUNDS - 1);
    localparam logic [ROUND_W-1:0] ROUND_P1   = ROUND_W'(20);
    localparam logic [ROUND_W-1:0] ROUND_P2   = ROUND_W'(40);
    localparam logic [ROUND_W-1:0] ROUND_P3   = ROUND_W'(60);
    localparam logic [ROUND_W-1:0] ROUND_SCHED = ROUND_W'(NUM_MSG);
    localparam logic [DIDX_W-1:0]  DIDX_LAST  = DIDX_W'(NUM_CHAIN - 1);
    localparam logic [IDX_W-1:0]   MSG_LAST   = IDX_W'(NUM_MSG - 1);
    localparam logic [IDX_W-1:0]   CHAIN_LIM  = IDX_W'(NUM_CHAIN);

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD
    } t_state;

    function automatic t_word rotl(input t_word v, input int unsigned s);
        rotl = (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic t_word round_f(input logic [ROUND_W-1:0] t,
                                      input t_word b, input t_word c,
                                      input t_word d);
        if (t < ROUND_P1) begin
            round_f = (b & c) | (~b & d);
        end else if (t < ROUND_P2) begin
            round_f = b ^ c ^ d;
        end else if (t < ROUND_P3) begin
            round_f = (b & c) | (b & d) | (c & d);
        end else begin
            round_f = b ^ c ^ d;
        end
    endfunction

    function automatic t_word round_k(input logic [ROUND_W-1:0] t);
        if (t < ROUND_P1) begin
            round_k = K0;
        end else if (t < ROUND_P2) begin
            round_k = K1;
        end else if (t < ROUND_P3) begin
            round_k = K2;
        end else begin
            round_k = K3;
        end
    endfunction

endpackage

// ----- rtl/sha1_block_compression.sv -----
// sha1 compression of one 512-bit block with a shared one-round-per-cycle unit
//
// input channel s_axis: one 32-bit word per item in tdata, tuser[0] is the
// command (0 loads chaining word H0..H4, 1 loads message word W0..W15) and
// tuser[4:1] the word position. chaining positions above 4 are dropped.
// loading message word 15 starts a compression: 80 rounds, one per cycle,
// then the five sums into the chaining words, one add per cycle while output is free.
// output channel m_axis: five items per compression, tdata the updated
// chaining word, tuser its index 0..4, tlast on index 4.
// after the word 15 item is accepted the rounds run, then each sum goes to
// the output register; digest words follow one per cycle while m_axis_tready
// is high. a full block spends most of its time in the 80 passes through
// the round unit.
// s_axis_tready is low from word 15 until the fifth sum is in the output
// register; the next block can load while that word waits to be taken.
// a stalled receiver holds the digest sequence in place.
// reset clears the chaining words, working variables and control state;
// the message window must be written before its first use.
module sha1_block_compression (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sha1bc_pkg::WORD_W-1:0]    s_axis_tdata,  // word
    input  logic [sha1bc_pkg::IN_USER_W-1:0] s_axis_tuser,  // cmd, word_index
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sha1bc_pkg::WORD_W-1:0]    m_axis_tdata,  // digest_word
    output logic [sha1bc_pkg::DIDX_W-1:0]    m_axis_tuser,  // digest_index
    output logic                             m_axis_tlast
);
    import sha1bc_pkg::*;

    t_state             r_state, n_state;
    t_word              r_h [NUM_CHAIN];
    t_word              r_v [NUM_CHAIN];
    t_word              r_w [NUM_MSG];
    logic [ROUND_W-1:0] r_round;
    logic [DIDX_W-1:0]  r_didx;
    logic               r_m_valid;
    t_word              r_m_data;
    logic [DIDX_W-1:0]  r_m_idx;
    logic               r_m_last;

    logic               in_acc;
    logic               in_cmd;
    logic [IDX_W-1:0]   in_idx;
    logic               start;
    logic               out_free;
    logic               do_add;
    t_word              sched_w;
    t_word              w_cur;
    t_word              tmp;
    t_word              sum;

    assign in_cmd   = s_axis_tuser[0];
    assign in_idx   = s_axis_tuser[IN_USER_W-1:1];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign start    = in_acc && (in_cmd == CMD_MSG) && (in_idx == MSG_LAST);
    assign out_free = !r_m_valid || m_axis_tready;
    assign do_add   = (r_state == ST_ADD) && out_free;

    // window index 0 holds w[t] in rounds 0..15, else w[t-16]; 13 w[t-3], 8 w[t-8], 2 w[t-14]
    assign sched_w = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    assign w_cur   = (r_round < ROUND_SCHED) ? r_w[0] : sched_w;
    assign tmp     = rotl(r_v[0], 5) + round_f(r_round, r_v[1], r_v[2], r_v[3])
                     + r_v[4] + round_k(r_round) + w_cur;
    assign sum     = r_h[r_didx] + r_v[r_didx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (start) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (out_free && r_didx == DIDX_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // round and sum counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
            r_didx  <= '0;
        end else begin
            if (r_state == ST_ROUND) begin
                r_round <= (r_round == ROUND_LAST) ? '0 : r_round + 1'b1;
            end
            if (do_add) begin
                r_didx <= (r_didx == DIDX_LAST) ? '0 : r_didx + 1'b1;
            end
        end
    end

    // chaining words and working variables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
                r_h[i] <= '0;
                r_v[i] <= '0;
            end
        end else begin
            if (in_acc && in_cmd == CMD_CHAIN && in_idx < CHAIN_LIM) begin
                r_h[in_idx[DIDX_W-1:0]] <= s_axis_tdata;
            end
            if (start) begin
                for (int i = 0; i < NUM_CHAIN; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
            if (r_state == ST_ROUND) begin
                r_v[0] <= tmp;
                r_v[1] <= r_v[0];
                r_v[2] <= rotl(r_v[1], 30);
                r_v[3] <= r_v[2];
                r_v[4] <= r_v[3];
            end
            if (do_add) begin
                r_h[r_didx] <= sum;
            end
        end
    end

    // message window, a shift line that comes back into slot order after 80 rounds
    always_ff @(posedge i_clk) begin
        if (in_acc && in_cmd == CMD_MSG) begin
            r_w[in_idx] <= s_axis_tdata;
        end
        if (r_state == ST_ROUND) begin
            for (int i = 0; i < NUM_MSG - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[NUM_MSG-1] <= w_cur;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (do_add) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_add) begin
            r_m_data <= sum;
            r_m_idx  <= r_didx;
            r_m_last <= (r_didx == DIDX_LAST);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_idx;
    assign m_axis_tlast  = r_m_last;

`ifndef SYNTHESIS
    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == ROUND_LAST) |=> (r_state == ST_ADD))
        else $error("round sequence did not end in the sum phase");

    a_round_zero_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_state == ST_ROUND && r_round == '0))
        else $error("compression did not start at round zero");

    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_round == '0 && r_didx == '0))
        else $error("counters not cleared while idle");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_last) |-> (r_m_idx == DIDX_LAST))
        else $error("last marker on wrong digest word");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !m_axis_tready) |=> (r_m_valid && $stable(r_m_data)
                                          && $stable(r_m_idx)))
        else $error("digest word changed while stalled");
`endif

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for sha1_block_compression: predicted digests, random stalls, backpressure
module tb_top;
    import sha1bc_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned TAIL_CYCLES  = 120;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASE_ITEMS  = 80;
    localparam int unsigned CHAIN_IDX_MAX = (1 << IDX_W) - 1;

    typedef struct packed {
        t_word             word;
        logic [DIDX_W-1:0] index;
        logic              last;
    } t_digest;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    t_word                s_axis_tdata = '0;
    logic [IN_USER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    t_word                m_axis_tdata;
    logic [DIDX_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    // predictor state
    t_word             chain_h [NUM_CHAIN];
    t_word             sched_w [NUM_MSG];
    logic [NUM_MSG-1:0] sched_loaded = '0;
    t_digest           digest_q [$];

    int unsigned err_cnt = 0;
    int unsigned loaded_items = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned idle_cycles = 0;
    logic        rx_hold = 1'b0;

    sha1_block_compression dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // word
        .s_axis_tuser  (s_axis_tuser),   // cmd, word_index
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // digest_word
        .m_axis_tuser  (m_axis_tuser),   // digest_index
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void compress_block();
        t_word a, b, c, d, e, f, k, w, sum;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < NUM_ROUNDS; t++) begin
            if (t < NUM_MSG) begin
                w = sched_w[t];
            end else begin
                w = sched_w[(t - 3) % 16] ^ sched_w[(t - 8) % 16] ^
                    sched_w[(t - 14) % 16] ^ sched_w[t % 16];
                w = {w[30:0], w[31]};
                sched_w[t % 16] = w;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void absorb_item(logic cmd, logic [IDX_W-1:0] idx, t_word w);
        t_digest dg;
        if (cmd == CMD_CHAIN) begin
            if (idx < CHAIN_LIM) chain_h[idx] = w;
        end else begin
            sched_w[idx] = w;
            if (idx == MSG_LAST) begin
                compress_block();
                for (int i = 0; i < NUM_CHAIN; i++) begin
                    dg.word  = chain_h[i];
                    dg.index = DIDX_W'(i);
                    dg.last  = (DIDX_W'(i) == DIDX_LAST);
                    digest_q.push_back(dg);
                end
            end
        end
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(9))
            0: rand_word = '0;
            1: rand_word = '1;
            2: rand_word = t_word'(1) << $urandom_range(31);
            3: rand_word = ~(t_word'(1) << $urandom_range(31));
            default: rand_word = $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, t_word want, t_word got);
        $display("mismatch: %s expected %h got %h", what, want, got);
        err_cnt++;
    endtask

    // called and returns at a falling edge
    task automatic send_item(logic cmd, logic [IDX_W-1:0] idx, t_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= {idx, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        absorb_item(cmd, idx, w);
        if (cmd == CMD_MSG) begin
            sched_loaded[idx] = 1'b1;
            if (idx == MSG_LAST) sched_loaded = '1;
        end
        if (cmd == CMD_MSG || idx < CHAIN_LIM) loaded_items++;
        @(negedge i_clk);
    endtask

    task automatic send_random_block();
        int order [NUM_MSG-1];
        int j, tmp;
        if ($urandom_range(1)) begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
                if ($urandom_range(3) != 0) send_item(CMD_CHAIN, IDX_W'(i), rand_word());
            end
        end
        if ($urandom_range(4) == 0) begin
            send_item(CMD_CHAIN, IDX_W'($urandom_range(CHAIN_IDX_MAX, NUM_CHAIN)), rand_word());
        end
        for (int i = 0; i < NUM_MSG - 1; i++) order[i] = i;
        for (int i = NUM_MSG - 2; i > 0; i--) begin
            j = int'($urandom_range(i));
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NUM_MSG - 1; i++) begin
            if (!sched_loaded[order[i]] || $urandom_range(3) != 0) begin
                send_item(CMD_MSG, IDX_W'(order[i]), rand_word());
            end
        end
        // now and then the block is abandoned before word 15
        if ($urandom_range(9) != 0) send_item(CMD_MSG, MSG_LAST, rand_word());
    endtask

    task automatic send_noise();
        logic             cmd;
        logic [IDX_W-1:0] idx;
        cmd = 1'($urandom_range(1));
        idx = IDX_W'($urandom_range(CHAIN_IDX_MAX));
        if (cmd == CMD_MSG && idx == MSG_LAST && !(&sched_loaded[NUM_MSG-2:0])) begin
            idx = IDX_W'($urandom_range(NUM_MSG - 2));
        end
        send_item(cmd, idx, rand_word());
    endtask

    task automatic test_block_from_reset();
        // "abc" padded block on top of the cleared chaining words
        send_item(CMD_MSG, 4'd0, 32'h6162_6380);
        for (int i = 1; i < NUM_MSG - 1; i++) send_item(CMD_MSG, IDX_W'(i), '0);
        send_item(CMD_MSG, MSG_LAST, 32'h0000_0018);
    endtask

    task automatic test_chain_and_leftovers();
        send_item(CMD_CHAIN, 4'd0, '1);
        send_item(CMD_CHAIN, 4'd1, '0);
        send_item(CMD_CHAIN, 4'd2, 32'h98BA_DCFE);
        send_item(CMD_CHAIN, 4'd3, 32'h1032_5476);
        send_item(CMD_CHAIN, 4'd4, 32'hC3D2_E1F0);
        // out of range positions must be dropped
        send_item(CMD_CHAIN, 4'd5, '1);
        send_item(CMD_CHAIN, 4'd15, 32'h1234_5678);
        // word 15 alone reuses the rolled window
        send_item(CMD_MSG, MSG_LAST, '1);
    endtask

    task automatic test_random_blocks(int unsigned tx_pct, int unsigned rx_pct);
        int unsigned start;
        send_idle_pct = tx_pct;
        stall_pct     = rx_pct;
        start = loaded_items;
        while (loaded_items - start < PHASE_ITEMS) begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(3, 1)) send_noise();
            end else begin
                send_random_block();
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        fork
            begin
                @(posedge i_clk);
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            begin
                repeat (3) begin
                    for (int i = 0; i < NUM_MSG; i++) send_item(CMD_MSG, IDX_W'(i), rand_word());
                end
            end
        join
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : digest_check
        t_digest want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest item", '0, m_axis_tdata);
            end else begin
                want = digest_q.pop_front();
                if (m_axis_tdata !== want.word) begin
                    report_mismatch("digest_word", want.word, m_axis_tdata);
                end
                if (m_axis_tuser !== want.index) begin
                    report_mismatch("digest_index", t_word'(want.index), t_word'(m_axis_tuser));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch("last", t_word'(want.last), t_word'(m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_CHAIN; i++) chain_h[i] = '0;
        for (int i = 0; i < NUM_MSG; i++) sched_w[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_block_from_reset();
        test_chain_and_leftovers();
        test_random_blocks(0, 0);
        test_random_blocks(69, 0);
        test_random_blocks(0, 69);
        test_random_blocks(12, 12);
        test_backpressure();
        test_random_blocks(0, 0);

        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && digest_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sha1bc_pkg.sv
rtl/sha1_block_compression.sv
sim/tb_top.sv
